// File: design/lnis_pkg.sv
// Shared command and status types for the longest non-increasing subsequence block.
package lnis_pkg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // Capture an input beat and set up the search bounds.
        logic search;    // Run one bisection step, or finish with the table write.
        logic cmp;       // Memory read data for the probe issued last cycle is valid.
        logic out_load;  // Move the finished result into the output register.
    } lnis_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic more;      // The search interval is not empty yet.
    } lnis_status_t;

endpackage

// File: design/lnis_if.sv
// Valid/ready channel interfaces for input beats and result beats.
interface lnis_in_if #(
    parameter int VALUE_BITS = 16
) ();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] height;
    logic                  first;

    modport source (output valid, output height, output first, input ready);
    modport sink (input valid, input height, input first, output ready);
endinterface

interface lnis_out_if #(
    parameter int LEN_BITS = 11
) ();
    logic                valid;
    logic                ready;
    logic [LEN_BITS-1:0] best_length;
    logic                overflow;

    modport source (output valid, output best_length, output overflow, input ready);
    modport sink (input valid, input best_length, input overflow, output ready);
endinterface

// File: design/lnis_ram.sv
// Generic single-port RAM with a registered read.
module lnis_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One access a cycle: a write, and a read of the same address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/lnis_datapath.sv
// Datapath: bisection bounds, tail memory, length register and result register.
module lnis_datapath #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_BITS  = 16,
    parameter int IDX_BITS    = $clog2(TABLE_DEPTH),
    parameter int LEN_BITS    = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lnis_pkg::lnis_cmd_t     cmd,
    output lnis_pkg::lnis_status_t  status,
    input  logic [VALUE_BITS-1:0]   height,
    input  logic                    first,
    output logic [LEN_BITS-1:0]     best_length,
    output logic                    overflow
);
    import lnis_pkg::*;

    localparam logic [LEN_BITS-1:0] DEPTH_LEN = LEN_BITS'(TABLE_DEPTH);
    localparam logic [LEN_BITS-1:0] ONE_LEN   = LEN_BITS'(1);

    logic [VALUE_BITS-1:0] h_reg;
    logic [LEN_BITS-1:0]   lo_reg;
    logic [LEN_BITS-1:0]   hi_reg;
    logic [LEN_BITS-1:0]   mid_reg;
    logic [LEN_BITS-1:0]   len_reg;
    logic [LEN_BITS-1:0]   len_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic [LEN_BITS-1:0]   best_length_reg;
    logic                  overflow_reg;

    logic [LEN_BITS-1:0]   lo_c;
    logic [LEN_BITS-1:0]   hi_c;
    logic [LEN_BITS-1:0]   mid_c;
    logic [LEN_BITS-1:0]   span_c;
    logic                  more_c;
    logic                  ram_we;
    logic [LEN_BITS-1:0]   wr_pos;
    logic [IDX_BITS-1:0]   ram_addr;
    logic [VALUE_BITS-1:0] ram_rdata;

    // Narrow the search interval with the tail read for the last probe.
    always_comb
    begin
        lo_c = lo_reg;
        hi_c = hi_reg;
        if (cmd.cmp)
        begin
            if (ram_rdata < h_reg)
            begin
                hi_c = mid_reg;
            end
            else
            begin
                lo_c = mid_reg + ONE_LEN;
            end
        end
        more_c = lo_c < hi_c;
        span_c = hi_c - lo_c;
        mid_c  = lo_c + (span_c >> 1);
    end

    assign status.more = more_c;

    // When the interval closes, overwrite the found entry, append, or flag overflow when the table is full.
    always_comb
    begin
        ram_we   = 1'b0;
        wr_pos   = lo_c;
        len_next = len_reg;
        ovf_next = ovf_reg;
        if (cmd.load)
        begin
            len_next = first ? '0 : len_reg;
            ovf_next = 1'b0;
        end
        else if (cmd.search && !more_c)
        begin
            priority if (lo_c < len_reg)
            begin
                ram_we = 1'b1;
            end
            else if (len_reg < DEPTH_LEN)
            begin
                ram_we   = 1'b1;
                wr_pos   = len_reg;
                len_next = len_reg + ONE_LEN;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    // The probe address follows the new bounds, so one probe goes out each cycle.
    assign ram_addr = ram_we ? wr_pos[IDX_BITS-1:0] : mid_c[IDX_BITS-1:0];

    lnis_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_tail_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (h_reg),
        .rdata (ram_rdata)
    );

    // Table length is control state and clears at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    // Payload, bound, overflow flag and result registers.
    always_ff @(posedge clk)
    begin
        ovf_reg <= ovf_next;
        if (cmd.load)
        begin
            h_reg  <= height;
            lo_reg <= '0;
            hi_reg <= first ? '0 : len_reg;
        end
        else if (cmd.search)
        begin
            lo_reg  <= lo_c;
            hi_reg  <= hi_c;
            mid_reg <= mid_c;
        end
        if (cmd.out_load)
        begin
            best_length_reg <= len_reg;
            overflow_reg    <= ovf_reg;
        end
    end

    assign best_length = best_length_reg;
    assign overflow    = overflow_reg;

    // The table never grows past its depth.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= DEPTH_LEN)
        else $error("table length exceeds the table depth");

    // A dropped append is only reported with a full table.
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && ovf_reg |-> len_reg == DEPTH_LEN)
        else $error("overflow reported while the table has room");

    // Each compare shrinks the interval and keeps it inside the table.
    a_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.search && cmd.cmp |-> lo_c >= lo_reg && hi_c <= hi_reg && hi_c <= len_reg)
        else $error("search interval grew or left the table");

endmodule

// File: design/lnis_ctrl.sv
// Controller: sequences capture, bisection and result hand-off.
module lnis_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    output lnis_pkg::lnis_cmd_t     cmd,
    input  lnis_pkg::lnis_status_t  status
);
    import lnis_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   cmp_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Commands decoded from the current state.
    always_comb
    begin
        cmd.load     = (state_reg == ST_IDLE) && in_valid;
        cmd.search   = (state_reg == ST_SEARCH);
        cmd.cmp      = cmp_reg;
        cmd.out_load = (state_reg == ST_DONE) && out_free;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmp_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    cmp_reg <= 1'b0;
                    if (in_valid)
                    begin
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    if (status.more)
                    begin
                        cmp_reg <= 1'b1;
                    end
                    else
                    begin
                        cmp_reg   <= 1'b0;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    cmp_reg <= 1'b0;
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    cmp_reg   <= 1'b0;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A pending compare only exists while searching.
    a_cmp_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_reg |-> state_reg == ST_SEARCH)
        else $error("compare flagged outside the search");

    // An accepted beat starts a search with no stale compare.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_SEARCH && !cmp_reg)
        else $error("search did not start cleanly after an input beat");

    // A finished result waits while the output register is still occupied.
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && out_valid_reg && !out_ready |=> state_reg == ST_DONE)
        else $error("result handed off over an occupied output register");

endmodule

// File: design/longest_nonincreasing_subsequence.sv
// Top level of the longest non-increasing subsequence block (patience tail table).
//
//   channel  dir  fields                                  handshake
//   item     in   height[VALUE_BITS-1:0], first           valid/ready
//   result   out  best_length[LEN_BITS-1:0], overflow     valid/ready
//
// An accepted item is searched by bisection over the current table length, then
// written into the table; its result is loaded once the output register is free,
// and only then is the next item accepted.
// The tail memory has a single port, so the search issues one bisection probe per cycle.
// Reset clears the table length; the tail memory is not cleared.
// The next item is accepted while a result waits in the output register.
module longest_nonincreasing_subsequence #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_BITS  = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    lnis_in_if.sink          item,
    lnis_out_if.source       result
);
    import lnis_pkg::*;

    localparam int IDX_BITS = $clog2(TABLE_DEPTH);
    localparam int LEN_BITS = $clog2(TABLE_DEPTH + 1);

    lnis_cmd_t    cmd;
    lnis_status_t status;

    // Sequencing.
    lnis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Search, table update and result register.
    lnis_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS),
        .IDX_BITS    (IDX_BITS),
        .LEN_BITS    (LEN_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .height      (item.height),
        .first       (item.first),
        .best_length (result.best_length),
        .overflow    (result.overflow)
    );

endmodule

// File: verif/tb.sv
// Self-checking testbench for the longest non-increasing subsequence block.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH    = 1024;
    localparam int VALUE_BITS     = 16;
    localparam int LEN_BITS       = 11;
    localparam int RANDOM_ITEMS   = 550;
    localparam int FILL_EXTRA     = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int GAP_PERCENT    = 8;

    typedef struct packed {
        logic [LEN_BITS-1:0] len;
        logic                ovf;
    } length_beat_t;

    // One row of the directed table; typed rows carry their own expected result.
    typedef struct packed {
        logic [VALUE_BITS-1:0] height;
        logic                  first;
        logic                  typed;
        logic [LEN_BITS-1:0]   len;
        logic                  ovf;
    } directed_row_t;

    typedef enum logic [1:0] {
        SHAPE_WIDE,
        SHAPE_NARROW,
        SHAPE_FALLING
    } shape_t;

    localparam int DIRECTED_ROWS = 18;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{16'd1000,  1'b0, 1'b1, 11'd1, 1'b0},  // empty table after reset appends
        '{16'd1000,  1'b0, 1'b1, 11'd2, 1'b0},  // equal to the last tail appends
        '{16'hFFFF,  1'b0, 1'b0, 11'd0, 1'b0},
        '{16'd0,     1'b0, 1'b1, 11'd3, 1'b0},
        '{16'd0,     1'b0, 1'b1, 11'd4, 1'b0},
        '{16'd1,     1'b0, 1'b0, 11'd0, 1'b0},
        '{16'hFFFF,  1'b1, 1'b1, 11'd1, 1'b0},  // first clears the table
        '{16'hFFFF,  1'b0, 1'b1, 11'd2, 1'b0},
        '{16'd0,     1'b1, 1'b1, 11'd1, 1'b0},
        '{16'hFFFF,  1'b0, 1'b0, 11'd0, 1'b0},
        '{16'h8000,  1'b0, 1'b0, 11'd0, 1'b0},
        '{16'h7FFF,  1'b0, 1'b0, 11'd0, 1'b0},
        '{16'hAAAA,  1'b0, 1'b0, 11'd0, 1'b0},
        '{16'h5555,  1'b0, 1'b0, 11'd0, 1'b0},
        '{16'h5555,  1'b0, 1'b0, 11'd0, 1'b0},
        '{16'd1,     1'b1, 1'b1, 11'd1, 1'b0},
        '{16'd2,     1'b0, 1'b0, 11'd0, 1'b0},
        '{16'd2,     1'b0, 1'b0, 11'd0, 1'b0}
    };

    logic clk;
    logic rst_n;

    lnis_in_if #(.VALUE_BITS(VALUE_BITS)) item_ch ();
    lnis_out_if #(.LEN_BITS(LEN_BITS)) result_ch ();

    longest_nonincreasing_subsequence #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .result(result_ch)
    );

    // Shadow copy of the tail table and its fill level.
    logic [VALUE_BITS-1:0] tails [TABLE_DEPTH];
    int                    tail_count = 0;

    length_beat_t pending_lengths [$];
    length_beat_t popped;

    bit gaps_on      = 1'b1;
    bit hold_request = 1'b0;
    int mismatches   = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int drops_seen   = 0;
    int restarts     = 0;
    int longest_seen = 0;
    int quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Reset is asserted at the start and never again.
    initial
    begin
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Patience step: overwrite the first tail strictly below h, else append, or flag overflow when full.
    function automatic void patience_step(input logic [VALUE_BITS-1:0] h, input logic f,
                                          output length_beat_t res);
        int lo;
        int hi;
        int mid;
        if (f)
            tail_count = 0;
        lo = 0;
        hi = tail_count;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (tails[mid] < h)
                hi = mid;
            else
                lo = mid + 1;
        end
        res.ovf = 1'b0;
        if (lo < tail_count)
            tails[lo] = h;
        else if (tail_count < TABLE_DEPTH)
        begin
            tails[tail_count] = h;
            tail_count++;
        end
        else
            res.ovf = 1'b1;
        res.len = tail_count[LEN_BITS-1:0];
    endfunction

    // Offers one item beat and records its expected result once it is taken.
    task automatic offer_beat(input logic [VALUE_BITS-1:0] h, input logic f,
                              input logic typed, input logic [LEN_BITS-1:0] tlen,
                              input logic tovf);
        length_beat_t want;
        while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.height <= h;
        item_ch.first  <= f;
        @(posedge clk);
        while (!item_ch.ready)
        begin
            @(posedge clk);
        end
        patience_step(h, f, want);
        if (typed)
        begin
            want.len = tlen;
            want.ovf = tovf;
        end
        pending_lengths.push_back(want);
        items_sent++;
        if (f)
            restarts++;
    endtask

    // One random sequence of the given shape; a few carry a stray restart.
    task automatic random_sequence(input int n, input shape_t shape, input bit fresh);
        logic [VALUE_BITS-1:0] h;
        int                    level;
        logic                  f;
        level = $urandom_range(30000, 65535);
        for (int i = 0; i < n; i++)
        begin
            unique case (shape)
                SHAPE_NARROW: h = VALUE_BITS'($urandom_range(0, 7));
                SHAPE_FALLING:
                begin
                    if ($urandom_range(0, 99) < 15)
                        level = $urandom_range(level, 65535);
                    else
                        level = (level > 400) ? level - $urandom_range(0, 400) : 0;
                    h = level[VALUE_BITS-1:0];
                end
                default: h = VALUE_BITS'($urandom_range(0, 65535));
            endcase
            f = (i == 0) ? fresh : ($urandom_range(0, 99) < 3);
            offer_beat(h, f, 1'b0, '0, 1'b0);
        end
    endtask

    // Stimulus: directed rows, a run that fills the table, then random sequences.
    initial
    begin
        int     level;
        int     random_done;
        int     n;
        shape_t shape;
        item_ch.valid  <= 1'b0;
        item_ch.height <= '0;
        item_ch.first  <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
            offer_beat(DIRECTED[r].height, DIRECTED[r].first, DIRECTED[r].typed,
                       DIRECTED[r].len, DIRECTED[r].ovf);

        // Fill the table with a non-increasing run, then push past full.
        level = 65535;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            offer_beat(level[VALUE_BITS-1:0], i == 0, 1'b0, '0, 1'b0);
            level = (level > 60) ? level - $urandom_range(0, 60) : 0;
        end
        for (int i = 0; i < FILL_EXTRA; i++)
        begin
            if (i % 3 == 2)
                offer_beat(VALUE_BITS'($urandom_range(level, 65535)), 1'b0, 1'b0, '0, 1'b0);
            else
                offer_beat(VALUE_BITS'($urandom_range(0, level)), 1'b0, 1'b0, '0, 1'b0);
        end

        // Random sequences; the first stretch runs with no idling on either side.
        random_done = 0;
        while (random_done < RANDOM_ITEMS)
        begin
            gaps_on = (random_done >= 150);
            if (random_done >= 300 && random_done < 340)
                hold_request = 1'b1;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
            shape = shape_t'($urandom_range(0, 2));
            random_sequence(n, shape, $urandom_range(0, 9) != 0);
            random_done += n;
        end
        item_ch.valid <= 1'b0;
        gaps_on = 1'b1;

        // Drain every expected result, then idle for DRAIN_CYCLES to catch any stray beat.
        while (pending_lengths.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d items sent, %0d results checked, %0d mismatches",
                 items_sent, results_seen, mismatches);
        $display("tb: %0d restarts, longest table %0d, %0d dropped appends seen",
                 restarts, longest_seen, drops_seen);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_ch.ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(posedge clk);
            end
            else
                result_ch.ready <= !(gaps_on && $urandom_range(0, 99) < GAP_PERCENT);
        end
    end

    // Compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (result_ch.overflow)
                drops_seen++;
            if (result_ch.best_length > longest_seen)
                longest_seen = int'(result_ch.best_length);
            if (pending_lengths.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: best_length %0d overflow %0b",
                         $time, result_ch.best_length, result_ch.overflow);
                mismatches++;
            end
            else
            begin
                popped = pending_lengths.pop_front();
                if (result_ch.best_length !== popped.len)
                begin
                    $display("%0t: best_length expected %0d, got %0d",
                             $time, popped.len, result_ch.best_length);
                    mismatches++;
                end
                if (result_ch.overflow !== popped.ovf)
                begin
                    $display("%0t: overflow expected %0b, got %0b",
                             $time, popped.ovf, result_ch.overflow);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
